// ===== src/rsm_pkg.sv =====
package rsm_pkg;

  localparam int unsigned SumW = 23;   // up to 64 terms of at most 2^16
  localparam int unsigned TermW = 17;  // Q1.16
  localparam int unsigned DivSteps = 17;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [31:0] StepQ32 = 32'd4283353945;

  typedef struct packed {
    logic signed [15:0] logit;
    logic               row_end;
  } in_req_t;

  typedef struct packed {
    logic [16:0] prob;
    logic [5:0]  col_index;
    logic        final_out;
    logic        overflow;
  } out_req_t;

  typedef struct packed {
    logic              start;
    logic [TermW-1:0]  term;
    logic [SumW-1:0]   sum;
  } div_req_t;

  typedef logic [TermW-1:0] exp_tbl_t [256];

  // 2^(-i/256) in Q1.16, built at elaboration by a Q32 recurrence
  function automatic exp_tbl_t build_tbl();
    exp_tbl_t    t;
    logic [63:0] a;
    a = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      t[i] = TermW'((a + 64'd32768) >> 16);
      a = (a * {32'd0, StepQ32} + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam exp_tbl_t ExpTbl = build_tbl();

endpackage

// ===== src/rsm_exp.sv =====
module rsm_exp (
  input  logic                        clk_i,
  input  logic [15:0]                 diff_i,
  output logic [rsm_pkg::TermW-1:0]   term_o
);

  logic [32:0] prod_q;
  logic [32:0] prod_d;
  logic [32:0] rnd;
  logic [16:0] k;
  logic [8:0]  n;

  assign prod_d = 33'(diff_i) * 33'(rsm_pkg::Log2eQ16);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // exponent in Q24 rounded to Q8: integer part shifts, fraction indexes table
  assign rnd = prod_q + 33'd32768;
  assign k   = rnd[32:16];
  assign n   = k[16:8];

  always_comb begin
    if (n >= 9'd17) begin
      term_o = '0;
    end else begin
      term_o = rsm_pkg::ExpTbl[k[7:0]] >> n[4:0];
    end
  end

endmodule

// ===== src/rsm_div.sv =====
module rsm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rsm_pkg::div_req_t          req_i,
  output logic                       done_o,
  output logic [rsm_pkg::TermW-1:0]  quot_o
);

  localparam int unsigned SW = rsm_pkg::SumW;

  logic [SW-1:0]             rem_q, rem_d;
  logic [SW-1:0]             dvs_q;
  logic [rsm_pkg::TermW-1:0] lo_q, lo_d;
  logic [rsm_pkg::TermW-1:0] quot_q, quot_d;
  logic [4:0]                step_q, step_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [SW:0]               trial;

  assign trial = {rem_q, lo_q[rsm_pkg::TermW-1]};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // term < 2*sum, so the top bits already sit below the divisor
      rem_d  = SW'(req_i.term[rsm_pkg::TermW-1:1]);
      lo_d   = {req_i.term[0], 16'd0};
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = SW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[rsm_pkg::TermW-2:0], 1'b1};
      end else begin
        rem_d  = trial[SW-1:0];
        quot_d = {quot_q[rsm_pkg::TermW-2:0], 1'b0};
      end
      lo_d   = {lo_q[rsm_pkg::TermW-2:0], 1'b0};
      step_d = step_q + 5'd1;
      if (step_q == 5'(rsm_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
    if (req_i.start) begin
      dvs_q <= req_i.sum;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/row_softmax_unit.sv =====
// Row softmax over Q8.8 logits, one element per input request.
// Input channel: in_valid_i / in_stall_o carry in_req_i (logit, row_end).
// Output channel: out_valid_o / out_stall_i carry out_req_o (prob,
// col_index, final_out, overflow); a request moves when valid and not stall.
// Elements are taken one per cycle while a row is collected. The element
// with row_end starts the row pass: an exp pass that takes each element in
// turn (memory read, registered multiply, table shift and sum), then a
// divide pass over each element (term read, 17-step restoring divider,
// output).
// The input is stalled from row_end until the last result of the row is
// loaded into the output register.
// Elements past MAX_COLS are dropped and every result of that row carries
// overflow. A held result waits in the output register while out_stall_i is
// high; the sequencer waits with it before the next divide. Reset clears
// the row count, maximum and overflow flag; the row store needs no clearing.
module row_softmax_unit #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rsm_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsm_pkg::out_req_t out_req_o
);

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW = $clog2(MAX_COLS + 1);

  typedef enum logic [6:0] {
    S_IN     = 7'b0000001,
    S_RD     = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_EXP    = 7'b0001000,
    S_DRD    = 7'b0010000,
    S_DSTART = 7'b0100000,
    S_DWAIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic signed [15:0]         max_q, max_d;
  logic                       ovf_q, ovf_d;
  logic [AW-1:0]              idx_q, idx_d;
  logic [rsm_pkg::SumW-1:0]   sum_q, sum_d;
  logic                       out_valid_q, out_valid_d;
  rsm_pkg::out_req_t          out_q;

  logic signed [15:0]         logit_mem [MAX_COLS];
  logic [rsm_pkg::TermW-1:0]  term_mem  [MAX_COLS];
  logic signed [15:0]         logit_rd_q;
  logic [rsm_pkg::TermW-1:0]  term_rd_q;

  logic                       in_acc, out_acc, store_en, is_last;
  logic [15:0]                diff;
  logic [rsm_pkg::TermW-1:0]  term;
  rsm_pkg::div_req_t          div_req;
  logic                       div_done;
  logic [rsm_pkg::TermW-1:0]  quot;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign store_en = in_acc && (cnt_q < CW'(MAX_COLS));
  assign is_last  = (CW'(idx_q) == cnt_q - CW'(1));
  assign in_stall_o = (state_q != S_IN);

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      logit_mem[cnt_q[AW-1:0]] <= in_req_i.logit;
    end
    logit_rd_q <= logit_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXP) begin
      term_mem[idx_q] <= term;
    end
    term_rd_q <= term_mem[idx_q];
  end

  assign diff = 16'(max_q - logit_rd_q);

  rsm_exp u_exp (
    .clk_i  (clk_i),
    .diff_i (diff),
    .term_o (term)
  );

  assign div_req.start = (state_q == S_DSTART);
  assign div_req.term  = term_rd_q;
  assign div_req.sum   = sum_q;

  rsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    max_d       = max_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      S_IN: begin
        if (in_acc) begin
          if (store_en) begin
            cnt_d = cnt_q + 1'b1;
            if (in_req_i.logit > max_q) begin
              max_d = in_req_i.logit;
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (in_req_i.row_end) begin
            idx_d   = '0;
            sum_d   = '0;
            state_d = S_RD;
          end
        end
      end
      S_RD:  state_d = S_MUL;
      S_MUL: state_d = S_EXP;
      S_EXP: begin
        sum_d = sum_q + rsm_pkg::SumW'(term);
        if (is_last) begin
          idx_d   = '0;
          state_d = S_DRD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_DRD: begin
        if (!out_valid_q) begin
          state_d = S_DSTART;
        end else if (out_acc) begin
          out_valid_d = 1'b0;
          state_d     = S_DSTART;
        end
      end
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          out_valid_d = 1'b1;
          if (is_last) begin
            cnt_d   = '0;
            max_d   = -16'sd32768;
            ovf_d   = 1'b0;
            state_d = S_IN;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_DRD;
          end
        end
      end
      default: state_d = S_IN;
    endcase
    // last result of a row drains while the next row is collected or started
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      cnt_q       <= '0;
      max_q       <= -16'sd32768;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      max_q       <= max_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DWAIT && div_done) begin
      out_q.prob      <= quot;
      out_q.col_index <= 6'(idx_q);
      out_q.final_out <= is_last;
      out_q.overflow  <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_COLS))
    else $error("row count past MAX_COLS");

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.prob <= 17'd65536)
    else $error("probability above one");

  a_row_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWAIT && div_done && is_last) |=> (cnt_q == '0 && !ovf_q))
    else $error("row state not cleared after final result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DSTART) |-> !out_valid_q)
    else $error("divide started with a result still held");

endmodule

// ===== sim/rsm_checker.sv =====
`timescale 1ns / 1ps

module rsm_checker #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  rsm_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  rsm_pkg::out_req_t out_req_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [16:0]        pow2_frac [256];
  logic signed [15:0] row_vals [64];
  int                 row_len;
  logic signed [15:0] row_peak;
  logic               row_dropped;
  rsm_pkg::out_req_t  prob_fifo [$];

  initial begin
    logic [63:0] a;
    a = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      pow2_frac[i] = 17'((a + 64'd32768) >> 16);
      a = (a * 64'd4283353945 + (64'd1 << 31)) >> 32;
    end
  end

  function automatic logic [16:0] exp_q16(logic signed [15:0] x, logic signed [15:0] m);
    logic [15:0] d;
    logic [39:0] k;
    d = 16'(m - x);
    k = ({24'd0, d} * 40'd94548 + 40'd32768) >> 16;
    if ((k >> 8) >= 17) return 17'd0;
    return pow2_frac[k[7:0]] >> (k >> 8);
  endfunction

  task automatic take_element(rsm_pkg::in_req_t r);
    logic [16:0]       terms [64];
    logic [31:0]       total;
    rsm_pkg::out_req_t o;
    if (row_len < MAX_COLS) begin
      row_vals[row_len] = r.logit;
      row_len++;
      if (r.logit > row_peak) row_peak = r.logit;
    end else begin
      row_dropped = 1'b1;
    end
    if (!r.row_end) return;
    total = 0;
    for (int c = 0; c < row_len; c++) begin
      terms[c] = exp_q16(row_vals[c], row_peak);
      total += terms[c];
    end
    for (int c = 0; c < row_len; c++) begin
      o.prob = 17'(({32'd0, 15'd0, terms[c]} << 16) / {32'd0, total});
      o.col_index = 6'(c);
      o.final_out = (c + 1 == row_len);
      o.overflow = row_dropped;
      prob_fifo.push_back(o);
    end
    row_len = 0;
    row_peak = -16'sd32768;
    row_dropped = 1'b0;
  endtask

  always @(posedge clk_i) begin
    rsm_pkg::out_req_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      row_len = 0;
      row_peak = -16'sd32768;
      row_dropped = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_i) take_element(in_req_i);
      if (out_valid_i && !out_stall_i) begin
        if (prob_fifo.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_req_i);
          fail_count_o++;
        end else begin
          e = prob_fifo.pop_front();
          if (e.prob !== out_req_i.prob || e.col_index !== out_req_i.col_index ||
              e.final_out !== out_req_i.final_out || e.overflow !== out_req_i.overflow) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_req_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = prob_fifo.size();
  end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int MaxCols = 64;
  localparam int Limit = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rsm_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rsm_pkg::out_req_t out_req;
  int                fail_count, pending;
  int                idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  row_softmax_unit #(.MAX_COLS(MaxCols)) dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_req_o(out_req)
  );

  rsm_checker #(.MAX_COLS(MaxCols)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_req_i(out_req),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // valid drops only when a gap follows, so back-to-back requests keep it high
  task automatic send(logic signed [15:0] v, logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= '{logit: v, row_end: last};
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_row(int n, int mode);
    logic signed [15:0] base, v;
    base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = 16'($urandom);
        1: v = base + 16'($signed($urandom_range(2047)) - 1024);
        default: v = ($urandom_range(1)) ? 16'sh7fff : -16'sh8000;
      endcase
      send(v, i == n - 1);
    end
  endtask

  // out side: random stalls
  always @(posedge clk_i) begin
    if ($urandom_range(99) < 30) out_stall <= ~out_stall;
    else if ($urandom_range(99) < 5) out_stall <= ($urandom_range(3) == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Limit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, single element, equal values, far apart, overflow
    send(16'sh7fff, 1'b1);
    send(-16'sh8000, 1'b1);
    send(16'sh7fff, 1'b0); send(-16'sh8000, 1'b0); send(16'sh0000, 1'b1);
    send(16'sh0100, 1'b0); send(16'sh0100, 1'b0); send(16'sh0100, 1'b1);
    send(16'sh0000, 1'b0); send(16'shf000, 1'b0); send(16'sh0b00, 1'b1);
    send_row(MaxCols, 0);
    send_row(MaxCols + 3, 1);
    sent = 0;
    while (sent < 250) begin
      int n, p;
      p = $urandom_range(99);
      n = (p < 85) ? $urandom_range(8, 1) : (p < 95) ? $urandom_range(MaxCols, 9)
                                                     : $urandom_range(MaxCols + 4, MaxCols);
      send_row(n, $urandom_range(2));
      sent += n;
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ===== files.f =====
src/rsm_pkg.sv
src/rsm_exp.sv
src/rsm_div.sv
src/row_softmax_unit.sv
sim/rsm_checker.sv
sim/tb.sv
